/* rtl/page_mapping_cache_policy_macros.svh */
// ----------------------------------------------------------------------------
// Page mapping cache policy: assertion macros
// Shorthand for clocked checks, gated off while reset is held.
// ----------------------------------------------------------------------------
`ifndef PAGE_MAPPING_CACHE_POLICY_MACROS_SVH
`define PAGE_MAPPING_CACHE_POLICY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PMCP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PMCP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pmcp_pkg.sv */
// ----------------------------------------------------------------------------
// Page mapping cache policy: shared package
// Payload types, command codes, status codes and defaults.
// ----------------------------------------------------------------------------
package pmcp_pkg;

    localparam int PMCP_ENTRIES     = 4;
    localparam int PMCP_QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic CFG_PAGE_SIZE    = 1'b0;
    localparam logic CFG_IDLE_TIMEOUT = 1'b1;

    localparam logic [1:0] PAGE_SIZE_RESET    = 2'd0;
    localparam logic [7:0] IDLE_TIMEOUT_RESET = 8'd2;

    // Page size codes (codes 2 and 3 behave as 64 KiB)
    localparam logic [1:0] PAGE_4K  = 2'd0;
    localparam logic [1:0] PAGE_16K = 2'd1;

    // Input operations
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // Command kinds passed from front to back
    localparam logic [1:0] KIND_LOOKUP   = 2'd0;
    localparam logic [1:0] KIND_FLUSH    = 2'd1;
    localparam logic [1:0] KIND_BADFRAME = 2'd2;

    // Result status codes
    localparam logic [2:0] STATUS_HIT        = 3'd0;
    localparam logic [2:0] STATUS_FILLED     = 3'd1;
    localparam logic [2:0] STATUS_BAD_FRAME  = 3'd2;
    localparam logic [2:0] STATUS_MAP_FAILED = 3'd3;
    localparam logic [2:0] STATUS_FLUSHED    = 3'd4;

    typedef struct packed {
        logic        func;
        logic [41:0] byte_addr;
        logic [16:0] req_bytes;
        logic [31:0] now_seconds;
        logic        frame_ok;
        logic        map_ok;
    } pmcp_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  slot;
        logic        evicted_live;
        logic [3:0]  expired_mask;
        logic [3:0]  cleared_mask;
        logic [15:0] read_offset;
        logic [16:0] read_len;
    } pmcp_out_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        map_ok;
        logic [29:0] page;
        logic [31:0] now;
        logic [15:0] offset;
        logic [16:0] len;
    } pmcp_cmd_t;

endpackage

/* rtl/pmcp_front.sv */
// ----------------------------------------------------------------------------
// Page mapping cache policy: front end
// Accepts requests, classifies them, splits the address into page and
// offset and clamps the read length; holds one command for the queue.
// ----------------------------------------------------------------------------
module pmcp_front import pmcp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] page_size_code,
    input  logic       s_valid,
    output logic       s_ready,
    input  pmcp_in_t   s_data,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output pmcp_cmd_t  cmd_data
);

    logic       cmd_valid_reg;
    logic       cmd_valid_next;
    pmcp_cmd_t  cmd_reg;
    pmcp_cmd_t  cmd_next;
    logic       load;
    logic [16:0] psize;
    logic [29:0] page;
    logic [15:0] offset;
    logic [17:0] span;

    assign s_ready = !cmd_valid_reg || cmd_ready;
    assign load    = s_valid && s_ready;

    always_comb begin
        unique case (page_size_code)
            PAGE_4K: begin
                psize = 17'h01000;
                page  = s_data.byte_addr[41:12];
            end
            PAGE_16K: begin
                psize = 17'h04000;
                page  = {2'b00, s_data.byte_addr[41:14]};
            end
            default: begin
                psize = 17'h10000;
                page  = {4'b0000, s_data.byte_addr[41:16]};
            end
        endcase
    end

    assign offset = s_data.byte_addr[15:0] & 16'(psize - 17'd1);
    assign span   = {2'b00, offset} + {1'b0, s_data.req_bytes};

    always_comb begin
        cmd_next        = cmd_reg;
        cmd_next.map_ok = s_data.map_ok;
        cmd_next.page   = page;
        cmd_next.now    = s_data.now_seconds;
        cmd_next.offset = offset;
        // clamp to the page end
        if (span > {1'b0, psize}) begin
            cmd_next.len = psize - {1'b0, offset};
        end else begin
            cmd_next.len = s_data.req_bytes;
        end
        priority if (s_data.func == FUNC_FLUSH) begin
            cmd_next.kind = KIND_FLUSH;
        end else if (!s_data.frame_ok) begin
            cmd_next.kind = KIND_BADFRAME;
        end else begin
            cmd_next.kind = KIND_LOOKUP;
        end
    end

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        if (load) begin
            cmd_valid_next = 1'b1;
        end else if (cmd_ready) begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd_data  = cmd_reg;

endmodule

/* rtl/pmcp_queue.sv */
// ----------------------------------------------------------------------------
// Page mapping cache policy: command queue
// Short first-in first-out buffer between the front end and the walker.
// ----------------------------------------------------------------------------
module pmcp_queue import pmcp_pkg::*; #(
    parameter int DEPTH = PMCP_QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  pmcp_cmd_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output pmcp_cmd_t rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pmcp_cmd_t          store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign wr_ready = count_reg != CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = store[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/pmcp_back.sv */
// ----------------------------------------------------------------------------
// Page mapping cache policy: entry walker
// Holds the entries, walks them one per cycle for a lookup, fills a mapped
// miss, clears on a flush and registers the result for the output channel.
// ----------------------------------------------------------------------------
`include "page_mapping_cache_policy_macros.svh"

module pmcp_back import pmcp_pkg::*; #(
    parameter int ENTRIES = PMCP_ENTRIES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] idle_timeout,
    input  logic       q_valid,
    output logic       q_ready,
    input  pmcp_cmd_t  q_data,
    output logic       m_valid,
    input  logic       m_ready,
    output pmcp_out_t  m_data
);

    localparam int IDX_W = $clog2(ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    pmcp_cmd_t          cmd_reg, cmd_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]   empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]   oldest_idx_reg, oldest_idx_next;
    logic [31:0]        oldest_time_reg, oldest_time_next;
    logic [3:0]         expired_reg, expired_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic               m_valid_reg, m_valid_next;
    pmcp_out_t          m_data_reg, m_data_next;

    logic [29:0]        page_mem [ENTRIES];
    logic [31:0]        last_mem [ENTRIES];

    logic               rd_valid;
    logic [29:0]        rd_page;
    logic [31:0]        rd_last;
    logic               page_match;
    logic [32:0]        age;
    logic               stale;
    logic               older;
    logic               idx_last;
    logic [4:0]         idx_ext;
    logic [4:0]         hit_ext;
    logic [4:0]         pick_ext;
    logic [IDX_W-1:0]   pick_idx;
    logic [ENTRIES+3:0] valid_ext;
    logic               out_free;
    logic               out_load;
    logic               last_we;
    logic               page_we;
    logic [IDX_W-1:0]   wr_idx;

    assign rd_valid   = valid_reg[idx_reg];
    assign rd_page    = page_mem[idx_reg];
    assign rd_last    = last_mem[idx_reg];
    assign page_match = rd_page == cmd_reg.page;
    assign age        = {1'b0, cmd_reg.now} - {1'b0, rd_last};
    assign stale      = !age[32] && (age[31:0] > {24'd0, idle_timeout});
    assign older      = rd_last < oldest_time_reg;
    assign idx_last   = idx_reg == IDX_W'(ENTRIES - 1);
    assign pick_idx   = empty_found_reg ? empty_idx_reg : oldest_idx_reg;
    assign idx_ext    = 5'(idx_reg);
    assign hit_ext    = 5'(hit_idx_reg);
    assign pick_ext   = 5'(pick_idx);
    assign valid_ext  = {4'b0000, valid_reg};
    assign out_free   = !m_valid_reg || m_ready;
    assign q_ready    = state_reg == ST_IDLE;

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cmd_next         = cmd_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        oldest_idx_next  = oldest_idx_reg;
        oldest_time_next = oldest_time_reg;
        expired_next     = expired_reg;
        valid_next       = valid_reg;
        m_data_next      = m_data_reg;
        out_load         = 1'b0;
        last_we          = 1'b0;
        page_we          = 1'b0;
        wr_idx           = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next         = q_data;
                    idx_next         = '0;
                    hit_next         = 1'b0;
                    empty_found_next = 1'b0;
                    oldest_idx_next  = '0;
                    oldest_time_next = q_data.now;
                    expired_next     = '0;
                    state_next       = (q_data.kind == KIND_LOOKUP) ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                if (rd_valid && page_match) begin
                    // first hit ends the walk and refreshes the entry
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                    last_we      = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    if (rd_valid) begin
                        if (older) begin
                            oldest_time_next = rd_last;
                            oldest_idx_next  = idx_reg;
                        end
                        if (stale) begin
                            valid_next[idx_reg] = 1'b0;
                            empty_found_next    = 1'b1;
                            empty_idx_next      = idx_reg;
                            if (idx_ext < 5'd4) begin
                                expired_next[idx_ext[1:0]] = 1'b1;
                            end
                        end
                    end else if (!empty_found_reg) begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = idx_reg;
                    end
                    if (idx_last) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    state_next  = ST_IDLE;
                    m_data_next = '0;
                    unique case (cmd_reg.kind)
                        KIND_FLUSH: begin
                            m_data_next.status       = STATUS_FLUSHED;
                            m_data_next.cleared_mask = valid_ext[3:0];
                            valid_next               = '0;
                        end
                        KIND_LOOKUP: begin
                            m_data_next.expired_mask = expired_reg;
                            m_data_next.read_offset  = cmd_reg.offset;
                            m_data_next.read_len     = cmd_reg.len;
                            if (hit_reg) begin
                                m_data_next.status = STATUS_HIT;
                                m_data_next.slot   = hit_ext[1:0];
                            end else begin
                                m_data_next.slot         = pick_ext[1:0];
                                m_data_next.evicted_live = valid_reg[pick_idx];
                                wr_idx                   = pick_idx;
                                if (cmd_reg.map_ok) begin
                                    m_data_next.status   = STATUS_FILLED;
                                    valid_next[pick_idx] = 1'b1;
                                    last_we              = 1'b1;
                                    page_we              = 1'b1;
                                end else begin
                                    m_data_next.status      = STATUS_MAP_FAILED;
                                    m_data_next.read_offset = '0;
                                    m_data_next.read_len    = '0;
                                    valid_next[pick_idx]    = 1'b0;
                                end
                            end
                        end
                        default: begin
                            m_data_next.status = STATUS_BAD_FRAME;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        cmd_reg         <= cmd_next;
        hit_reg         <= hit_next;
        hit_idx_reg     <= hit_idx_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        oldest_idx_reg  <= oldest_idx_next;
        oldest_time_reg <= oldest_time_next;
        expired_reg     <= expired_next;
        m_data_reg      <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (last_we) begin
            last_mem[wr_idx] <= cmd_reg.now;
        end
        if (page_we) begin
            page_mem[wr_idx] <= cmd_reg.page;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PMCP_ASSERT_NOW(a_walk_in_range, aclk, aresetn, state_reg == ST_WALK, idx_ext < 5'(ENTRIES), "walk index beyond last entry")
    `PMCP_ASSERT_NEXT(a_pop_starts, aclk, aresetn, q_valid && q_ready, state_reg != ST_IDLE, "command taken but walker idle")
    `PMCP_ASSERT_NEXT(a_hit_ends_walk, aclk, aresetn, (state_reg == ST_WALK) && rd_valid && page_match, (state_reg == ST_DONE) && hit_reg, "hit did not end the walk")
    `PMCP_ASSERT_NEXT(a_flush_empties, aclk, aresetn, out_load && (cmd_reg.kind == KIND_FLUSH), valid_reg == '0, "entries left valid after flush")
    `PMCP_ASSERT_NEXT(a_fill_valid, aclk, aresetn, out_load && (cmd_reg.kind == KIND_LOOKUP) && !hit_reg && cmd_reg.map_ok, valid_reg[$past(pick_idx)], "filled entry not valid")

endmodule

/* rtl/page_mapping_cache_policy.sv */
// ----------------------------------------------------------------------------
// Page mapping cache policy: top level
// Fully associative cache of page mappings with LRU fill and idle timeout.
// ----------------------------------------------------------------------------
// Requests enter on s_valid/s_ready with s_data (lookup or flush); one result
// per request leaves on m_valid/m_ready with m_data, in request order.
// Page size and idle timeout are set through cfg_wr_en/cfg_index/cfg_wdata;
// the user writes them only while no request is in flight (not enforced).
// A lookup passes through the classify register, the command queue, the
// walk (one entry per cycle) and the install/result register; a hit stops
// the walk early, and flushes and refused frames skip the walk. The walker
// takes the next command only once the current result is loaded into the
// output register.
// A two-deep command queue sits between classification and the walker, so
// requests keep being taken while the walker is busy or the result waits.
// Reset (aresetn low, synchronous) empties the queue, invalidates every
// entry and restores page size 4 KiB and a timeout of 2 seconds.
// When the receiver holds m_ready low the result is held steady; the walker
// then stalls, the queue fills and s_ready drops.
// ----------------------------------------------------------------------------
module page_mapping_cache_policy import pmcp_pkg::*; #(
    parameter int ENTRIES     = PMCP_ENTRIES,
    parameter int QUEUE_DEPTH = PMCP_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  pmcp_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output pmcp_out_t  m_data
);

    logic [1:0] page_size_reg, page_size_next;
    logic [7:0] timeout_reg, timeout_next;
    logic       cmd_valid;
    logic       cmd_ready;
    pmcp_cmd_t  cmd_data;
    logic       q_valid;
    logic       q_ready;
    pmcp_cmd_t  q_data;

    always_comb begin
        page_size_next = page_size_reg;
        timeout_next   = timeout_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PAGE_SIZE:    page_size_next = cfg_wdata[1:0];
                CFG_IDLE_TIMEOUT: timeout_next   = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_size_reg <= PAGE_SIZE_RESET;
            timeout_reg   <= IDLE_TIMEOUT_RESET;
        end else begin
            page_size_reg <= page_size_next;
            timeout_reg   <= timeout_next;
        end
    end

    pmcp_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .page_size_code (page_size_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd_data       (cmd_data)
    );

    pmcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (cmd_valid),
        .wr_ready (cmd_ready),
        .wr_data  (cmd_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    pmcp_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .idle_timeout (timeout_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule
